@@ design/lkvc_pkg.sv @@
// Shared constants, types and codes for the LRU key/value cache.
// No dependencies; used by every module of the block by scoped names.
package lkvc_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 32;
   localparam int DATA_W   = 32;
   localparam int CAP_W    = 5;
   localparam int KEY_W    = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W    = IDX_W;
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_SET = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [AGE_W-1:0]  age_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [DATA_W-1:0] data_type;

   // one compare beat presented to the scan unit
   typedef struct packed {
      logic     en;
      idx_type  idx;
      logic     valid;
      age_type  age;
      key_type  key;
      data_type value;
   } scan_beat_type;

   // accumulated outcome of a full scan
   typedef struct packed {
      logic     hit;
      idx_type  hit_idx;
      data_type hit_value;
      logic     free_found;
      idx_type  free_idx;
      logic     victim_found;
      idx_type  victim_idx;
   } scan_result_type;

endpackage

@@ design/lru_key_value_cache.sv @@
// Fully associative key/value cache with least-recently-used replacement, top level.
// Depends on lkvc_pkg, lkvc_store and lkvc_scan.
//
// A request beat is taken only when the block is idle; it then stays busy
// while the single key comparator steps through the key store one entry per
// cycle, then through a drain state that waits for the registered read of the
// last entry, and an update state; a new request is not taken before the last
// one is through. A get returns one response beat; a set returns none.
// A response waiting on rsp_stall does not block the next request, but a get
// holds in its update state until the response register is free. Writing the
// capacity register empties the cache at once; values above ENTRIES act as
// ENTRIES.
module lru_key_value_cache (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [31:0]        req_lookup_key,
   input  logic signed [31:0]        req_store_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [31:0]        rsp_read_value,
   input  logic                      csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      UPDATE
   } state_type;

   state_type state_ff, state_in;

   logic [lkvc_pkg::ENTRIES-1:0] valid_ff, valid_in;
   lkvc_pkg::age_type  age_ff [lkvc_pkg::ENTRIES];
   lkvc_pkg::age_type  age_in [lkvc_pkg::ENTRIES];
   lkvc_pkg::cnt_type  count_ff, count_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff, cap_in;

   lkvc_pkg::idx_type  rd_idx_ff,  rd_idx_in;
   logic               cmp_en_ff,  cmp_en_in;
   lkvc_pkg::idx_type  cmp_idx_ff, cmp_idx_in;
   logic               action_ff,  action_in;
   lkvc_pkg::key_type  key_ff,     key_in;
   lkvc_pkg::data_type value_ff,   value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   lkvc_pkg::data_type rsp_value_ff, rsp_value_in;

   lkvc_pkg::cnt_type         cap_eff;
   logic                      start;
   logic                      store_we;
   lkvc_pkg::idx_type         store_waddr;
   lkvc_pkg::key_type         rd_key;
   lkvc_pkg::data_type        rd_value;
   lkvc_pkg::scan_beat_type   beat;
   lkvc_pkg::scan_result_type result;
   logic                      promote_en;
   logic                      promote_all;
   lkvc_pkg::idx_type         promote_slot;
   lkvc_pkg::age_type         promote_limit;

   assign cap_eff = (int'(cap_ff) > lkvc_pkg::ENTRIES) ? lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES)
                                                      : lkvc_pkg::CNT_W'(cap_ff);
   assign start         = (state_ff == IDLE) && req_valid;
   assign promote_limit = age_ff[result.hit_idx];

   assign beat.en    = cmp_en_ff;
   assign beat.idx   = cmp_idx_ff;
   assign beat.valid = valid_ff[cmp_idx_ff];
   assign beat.age   = age_ff[cmp_idx_ff];
   assign beat.key   = rd_key;
   assign beat.value = rd_value;

   lkvc_store u_store (
      .clock    (clock),
      .wr_en    (store_we),
      .wr_addr  (store_waddr),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd_addr  (rd_idx_ff),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   lkvc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .beat       (beat),
      .lookup_key (key_ff),
      .result     (result)
   );

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      age_in       = age_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_en_in    = cmp_en_ff;
      cmp_idx_in   = cmp_idx_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      store_we     = 1'b0;
      store_waddr  = result.hit_idx;
      promote_en   = 1'b0;
      promote_all  = 1'b0;
      promote_slot = result.hit_idx;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            cmp_en_in = 1'b0;
            if (req_valid) begin
               action_in = req_action;
               key_in    = req_lookup_key[lkvc_pkg::KEY_W-1:0];
               value_in  = req_store_value;
               rd_idx_in = '0;
               state_in  = SCAN;
            end
         end
         SCAN: begin
            cmp_en_in  = 1'b1;
            cmp_idx_in = rd_idx_ff;
            if (rd_idx_ff == lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1)) begin
               state_in = DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + lkvc_pkg::IDX_W'(1);
            end
         end
         DRAIN: begin
            cmp_en_in = 1'b0;
            state_in  = UPDATE;
         end
         UPDATE: begin
            if (action_ff == lkvc_pkg::ACTION_GET) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = result.hit;
                  rsp_value_in = result.hit ? result.hit_value : '1;
                  promote_en   = result.hit;
                  state_in     = IDLE;
               end
            end else begin
               state_in = IDLE;
               if (cap_eff != '0) begin
                  if (result.hit) begin
                     store_we   = 1'b1;
                     promote_en = 1'b1;
                  end else if (count_ff < cap_eff) begin
                     if (result.free_found) begin
                        store_we                  = 1'b1;
                        store_waddr               = result.free_idx;
                        valid_in[result.free_idx] = 1'b1;
                        count_in                  = count_ff + lkvc_pkg::CNT_W'(1);
                        promote_en                = 1'b1;
                        promote_all               = 1'b1;
                        promote_slot              = result.free_idx;
                     end
                  end else if (result.victim_found) begin
                     store_we     = 1'b1;
                     store_waddr  = result.victim_idx;
                     promote_en   = 1'b1;
                     promote_all  = 1'b1;
                     promote_slot = result.victim_idx;
                  end
               end
            end
         end
         default: state_in = IDLE;
      endcase

      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (promote_en) begin
            if (promote_slot == lkvc_pkg::IDX_W'(i)) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (promote_all || (age_ff[i] < promote_limit))) begin
               age_in[i] = age_ff[i] + lkvc_pkg::AGE_W'(1);
            end
         end
      end

      if (csr_write_enable) begin
         cap_in   = csr_write_data;
         valid_in = '0;
         count_in = '0;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            age_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         rd_idx_ff    <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_en_ff    <= cmp_en_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
      end
      cmp_idx_ff   <= cmp_idx_in;
      action_ff    <= action_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // occupancy count tracks the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("valid count out of step with valid bits");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("occupancy above capacity");

   // a response beat only comes out of the update step of a get
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == UPDATE) &&
                              ($past(action_ff) == lkvc_pkg::ACTION_GET))
      else $error("response beat without a get");

endmodule

@@ design/lkvc_store.sv @@
// Key and value storage of the LRU cache: one write port, one registered read port.
// Depends on lkvc_pkg.
module lkvc_store (
   input  logic              clock,
   input  logic              wr_en,
   input  lkvc_pkg::idx_type  wr_addr,
   input  lkvc_pkg::key_type  wr_key,
   input  lkvc_pkg::data_type wr_value,
   input  lkvc_pkg::idx_type  rd_addr,
   output lkvc_pkg::key_type  rd_key,
   output lkvc_pkg::data_type rd_value
);

   lkvc_pkg::key_type  key_mem   [lkvc_pkg::ENTRIES];
   lkvc_pkg::data_type value_mem [lkvc_pkg::ENTRIES];
   lkvc_pkg::key_type  rd_key_ff;
   lkvc_pkg::data_type rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

@@ design/lkvc_scan.sv @@
// Shared compare unit: one entry per beat, tracks key hit, lowest free slot and oldest entry.
// Depends on lkvc_pkg.
module lkvc_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lkvc_pkg::scan_beat_type   beat,
   input  lkvc_pkg::key_type         lookup_key,
   output lkvc_pkg::scan_result_type result
);

   logic               hit_ff,          hit_in;
   lkvc_pkg::idx_type  hit_idx_ff,      hit_idx_in;
   lkvc_pkg::data_type hit_value_ff,    hit_value_in;
   logic               free_found_ff,   free_found_in;
   lkvc_pkg::idx_type  free_idx_ff,     free_idx_in;
   logic               victim_found_ff, victim_found_in;
   lkvc_pkg::idx_type  victim_idx_ff,   victim_idx_in;
   lkvc_pkg::age_type  victim_age_ff,   victim_age_in;

   always_comb begin
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_value_in    = hit_value_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_age_in   = victim_age_ff;
      if (start) begin
         hit_in          = 1'b0;
         free_found_in   = 1'b0;
         victim_found_in = 1'b0;
      end else if (beat.en) begin
         if (beat.valid && !hit_ff && (beat.key == lookup_key)) begin
            hit_in       = 1'b1;
            hit_idx_in   = beat.idx;
            hit_value_in = beat.value;
         end
         if (!beat.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = beat.idx;
         end
         if (beat.valid && (!victim_found_ff || (beat.age > victim_age_ff))) begin
            victim_found_in = 1'b1;
            victim_idx_in   = beat.idx;
            victim_age_in   = beat.age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff          <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
      end else begin
         hit_ff          <= hit_in;
         free_found_ff   <= free_found_in;
         victim_found_ff <= victim_found_in;
      end
      hit_idx_ff    <= hit_idx_in;
      hit_value_ff  <= hit_value_in;
      free_idx_ff   <= free_idx_in;
      victim_idx_ff <= victim_idx_in;
      victim_age_ff <= victim_age_in;
   end

   assign result.hit          = hit_ff;
   assign result.hit_idx      = hit_idx_ff;
   assign result.hit_value    = hit_value_ff;
   assign result.free_found   = free_found_ff;
   assign result.free_idx     = free_idx_ff;
   assign result.victim_found = victim_found_ff;
   assign result.victim_idx   = victim_idx_ff;

endmodule
